// ----- src/banked_memory_map_decoder_defines.svh -----
// ----------------------------------------------------------------------------
// Banked memory map decoder assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef BANKED_MEMORY_MAP_DECODER_DEFINES_SVH
`define BANKED_MEMORY_MAP_DECODER_DEFINES_SVH

// Check an implication or plain property every cycle out of reset.
`define BMMD_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bmmd assertion failed");

// Check that post holds in the cycle after pre.
`define BMMD_ASSERT_NEXT(name, pre, post) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error("bmmd assertion failed");

`endif

// ----- src/bmmd_pkg.sv -----
// ----------------------------------------------------------------------------
// Banked memory map decoder package
// Types, codes and address constants shared by the decoder modules.
// ----------------------------------------------------------------------------
package bmmd_pkg;

    localparam int RAM_BYTES = 98304;
    localparam int ROM_BYTES = 65536;
    localparam int RAM_AW    = $clog2(RAM_BYTES);
    localparam int ROM_AW    = $clog2(ROM_BYTES);

    // RAM index before the range check: 16-bit address plus a 2-bit bank at bit 14
    localparam int RAM_IDX_W = 17;
    localparam logic [RAM_IDX_W:0] RAM_LIMIT = (RAM_IDX_W + 1)'(RAM_BYTES);

    typedef enum logic [1:0] {
        FUNC_READ      = 2'd0,
        FUNC_WRITE     = 2'd1,
        FUNC_POWER_OFF = 2'd2,
        FUNC_ROM_LOAD  = 2'd3
    } func_t;

    typedef enum logic [2:0] {
        TGT_NONE    = 3'd0,
        TGT_TIMER   = 3'd1,
        TGT_PORT5   = 3'd2,
        TGT_LCD     = 3'd3,
        TGT_TRIGGER = 3'd4
    } target_t;

    typedef enum logic [3:0] {
        ACT_NONE          = 4'd0,
        ACT_SWITCH_OFF    = 4'd1,
        ACT_PULSE_ON      = 4'd2,
        ACT_PULSE_OFF     = 4'd3,
        ACT_COUNTER_RESET = 4'd4,
        ACT_COUNTER_INC   = 4'd5,
        ACT_NMI_ON        = 4'd6,
        ACT_NMI_OFF       = 4'd7,
        ACT_BANK_RESET    = 4'd8,
        ACT_NEXT_RAM_BANK = 4'd9,
        ACT_NEXT_ROM_BANK = 4'd10
    } action_t;

    typedef enum logic [1:0] {
        RD_CONST = 2'd0,
        RD_RAM   = 2'd1,
        RD_ROM   = 2'd2
    } rd_sel_t;

    typedef enum logic [1:0] {
        CFG_RAM_LOW_LIMIT  = 2'd0,
        CFG_RAM_HIGH_LIMIT = 2'd1,
        CFG_RAM_BANK_COUNT = 2'd2,
        CFG_ROM_BANK_COUNT = 2'd3
    } cfg_index_t;

    typedef struct packed {
        func_t       func;
        logic [15:0] address;
        logic [7:0]  write_data;
    } item_t;

    typedef struct packed {
        logic [13:0] ram_low_limit;
        logic [14:0] ram_high_limit;
        logic [2:0]  ram_bank_count;
        logic [2:0]  rom_bank_count;
    } cfg_t;

    typedef struct packed {
        rd_sel_t           rd_sel;
        logic [7:0]        rd_const;
        target_t           target;
        logic [5:0]        treg;
        action_t           action;
        logic              cmp;
        logic              ram_we;
        logic [RAM_AW-1:0] ram_addr;
        logic              rom_we;
        logic [ROM_AW-1:0] rom_addr;
        logic [1:0]        ram_bank_next;
        logic [1:0]        rom_bank_next;
    } dec_t;

    typedef struct packed {
        logic              ram_we;
        logic              ram_re;
        logic [RAM_AW-1:0] ram_addr;
        logic              rom_we;
        logic              rom_re;
        logic [ROM_AW-1:0] rom_addr;
        logic [7:0]        wdata;
    } mem_req_t;

endpackage

// ----- src/banked_memory_map_decoder.sv -----
// ----------------------------------------------------------------------------
// Banked memory map decoder
// Decodes CPU bus byte accesses, holds RAM/ROM stores and the bank pointers.
// ----------------------------------------------------------------------------
// Usage:
//   Slave stream carries one item per transfer: tuser = func (read, write,
//   power off, ROM load), tdata = address and write byte. Master stream
//   returns exactly one result per item, in order: the byte read, the
//   external unit targeted with its register, the trigger action, the
//   compare-write flag and both bank pointers after the item.
//   Throughput: one item per cycle while tready is held high and no clearing
//   pass runs. Each item passes an input register and a result register; the
//   store read port is registered in step with the result register, so the
//   read byte is valid as soon as m_tvalid rises.
//   Stall: when the receiver holds tready low, the result register holds,
//   the input register takes one more item, then s_tready drops.
//   Reset: bank pointers go to zero and configuration to its defaults, then a
//   clearing pass writes zero to every RAM byte, one byte per cycle, from
//   index 0 up to RAM_BYTES-1 (98303); s_tready stays low during the pass.
//   Configuration writes through cfg_we/cfg_index/cfg_data take effect on the
//   next clock; issue them only while no item is in flight (the pass counts).
// ----------------------------------------------------------------------------
`include "banked_memory_map_decoder_defines.svh"

module banked_memory_map_decoder
    import bmmd_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [14:0] cfg_data,
    // input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [23:0] s_tdata,   // [15:0] address, [23:16] write_data
    input  logic [1:0]  s_tuser,   // [1:0] func
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // [7:0] read_data, [10:8] target,
                                   // [16:11] target_register,
                                   // [20:17] trigger_action,
                                   // [21] compare_notify,
                                   // [23:22] ram_bank_now,
                                   // [25:24] rom_bank_now, [31:26] zero
);

    // Configuration registers
    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.ram_low_limit  <= 14'd8192;
            cfg_reg.ram_high_limit <= 15'd32767;
            cfg_reg.ram_bank_count <= 3'd1;
            cfg_reg.rom_bank_count <= 3'd1;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_RAM_LOW_LIMIT:  cfg_reg.ram_low_limit  <= cfg_data[13:0];
                CFG_RAM_HIGH_LIMIT: cfg_reg.ram_high_limit <= cfg_data;
                CFG_RAM_BANK_COUNT: cfg_reg.ram_bank_count <= cfg_data[2:0];
                CFG_ROM_BANK_COUNT: cfg_reg.rom_bank_count <= cfg_data[2:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    // Pipeline control
    logic     s1_valid_reg;
    item_t    s1_item_reg;
    logic     s2_valid_reg;
    logic     adv2;
    logic     move1;
    logic     store_busy;

    // Bank pointers, updated as each item leaves the input register
    logic [1:0] ram_bank_reg;
    logic [1:0] rom_bank_reg;

    // Result register
    rd_sel_t    s2_rd_sel_reg;
    logic [7:0] s2_rd_const_reg;
    target_t    s2_target_reg;
    logic [5:0] s2_treg_reg;
    action_t    s2_action_reg;
    logic       s2_cmp_reg;
    logic [1:0] s2_ram_bank_reg;
    logic [1:0] s2_rom_bank_reg;

    dec_t       dec;
    mem_req_t   mem_req;
    logic [7:0] ram_rdata;
    logic [7:0] rom_rdata;
    logic [7:0] read_data;

    // Advance the result register when empty or when its transfer completes
    assign adv2     = !s2_valid_reg || m_tready;
    assign move1    = s1_valid_reg && adv2;
    assign s_tready = !store_busy && (!s1_valid_reg || adv2);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            ram_bank_reg <= 2'd0;
            rom_bank_reg <= 2'd0;
        end
        else
        begin
            if (s_tready)
            begin
                s1_valid_reg <= s_tvalid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (move1)
            begin
                ram_bank_reg <= dec.ram_bank_next;
                rom_bank_reg <= dec.rom_bank_next;
            end
        end
    end

    // Capture the item payload on each input transfer
    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            s1_item_reg.func       <= func_t'(s_tuser);
            s1_item_reg.address    <= s_tdata[15:0];
            s1_item_reg.write_data <= s_tdata[23:16];
        end
    end

    bmmd_decode u_decode (
        .item     (s1_item_reg),
        .ram_bank (ram_bank_reg),
        .rom_bank (rom_bank_reg),
        .cfg      (cfg_reg),
        .dec      (dec)
    );

    // Store accesses fire only as the item moves into the result register,
    // so the registered read data lines up with it and holds while stalled
    always_comb
    begin
        mem_req.ram_we   = move1 && dec.ram_we;
        mem_req.ram_re   = move1 && (dec.rd_sel == RD_RAM);
        mem_req.ram_addr = dec.ram_addr;
        mem_req.rom_we   = move1 && dec.rom_we;
        mem_req.rom_re   = move1 && (dec.rd_sel == RD_ROM);
        mem_req.rom_addr = dec.rom_addr;
        mem_req.wdata    = s1_item_reg.write_data;
    end

    bmmd_store u_store (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (mem_req),
        .ram_rdata (ram_rdata),
        .rom_rdata (rom_rdata),
        .busy      (store_busy)
    );

    always_ff @(posedge clk)
    begin
        if (move1)
        begin
            s2_rd_sel_reg   <= dec.rd_sel;
            s2_rd_const_reg <= dec.rd_const;
            s2_target_reg   <= dec.target;
            s2_treg_reg     <= dec.treg;
            s2_action_reg   <= dec.action;
            s2_cmp_reg      <= dec.cmp;
            s2_ram_bank_reg <= dec.ram_bank_next;
            s2_rom_bank_reg <= dec.rom_bank_next;
        end
    end

    // Pick the read byte from the store that served this item
    always_comb
    begin
        case (s2_rd_sel_reg)
            RD_RAM:  read_data = ram_rdata;
            RD_ROM:  read_data = rom_rdata;
            default: read_data = s2_rd_const_reg;
        endcase
    end

    assign m_tvalid = s2_valid_reg;
    assign m_tdata  = {6'd0, s2_rom_bank_reg, s2_ram_bank_reg, s2_cmp_reg,
                       s2_action_reg, s2_treg_reg, s2_target_reg, read_data};

    // No item may sit in the input register while the RAM sweep owns the store
    `BMMD_ASSERT(a_no_item_during_clear, store_busy |-> !s1_valid_reg)

    // Bank pointers move only when an item leaves the input register
    `BMMD_ASSERT_NEXT(a_banks_hold, !move1, $stable(ram_bank_reg) && $stable(rom_bank_reg))

    // A trigger target always carries a nonzero action
    `BMMD_ASSERT(a_trigger_has_action, (s2_valid_reg && s2_target_reg == TGT_TRIGGER) |-> (s2_action_reg != ACT_NONE))

endmodule

// ----- src/bmmd_decode.sv -----
// ----------------------------------------------------------------------------
// Banked memory map decoder: address decode
// Decodes one registered bus item into result fields, store access and banks.
// ----------------------------------------------------------------------------
module bmmd_decode
    import bmmd_pkg::*;
(
    input  item_t      item,
    input  logic [1:0] ram_bank,
    input  logic [1:0] rom_bank,
    input  cfg_t       cfg,
    output dec_t       dec
);

    // Register window addresses
    localparam logic [5:0] REG_TIMER_CTRL  = 6'h08;
    localparam logic [5:0] REG_COUNTER_HI  = 6'h09;
    localparam logic [5:0] REG_COUNTER_LO  = 6'h0a;
    localparam logic [5:0] REG_CMP_HI      = 6'h0b;
    localparam logic [5:0] REG_CMP_LO      = 6'h0c;
    localparam logic [5:0] REG_TIMER_CTRL2 = 6'h0f;
    localparam logic [5:0] REG_SCRATCH_A   = 6'h10;
    localparam logic [5:0] REG_FIXED_20A   = 6'h11;
    localparam logic [5:0] REG_SCRATCH_B   = 6'h14;
    localparam logic [5:0] REG_PORT5       = 6'h15;
    localparam logic [5:0] REG_FIXED_FFA   = 6'h19;
    localparam logic [5:0] REG_FIXED_FFB   = 6'h1a;
    localparam logic [5:0] REG_FIXED_20B   = 6'h1b;

    localparam logic [15:0] BLOCK_MASK   = 16'hffe0;
    localparam logic [15:0] LCD_BASE     = 16'h0180;
    localparam logic [15:0] LCD_END      = 16'h01bf;
    localparam logic [15:0] TRIG_FIRST   = 16'h01c0;
    localparam logic [15:0] TRIG_LAST    = 16'h03ff;
    localparam logic [15:0] TRIG_OFF     = 16'h01c0;
    localparam logic [15:0] TRIG_P_ON    = 16'h0200;
    localparam logic [15:0] TRIG_P_OFF   = 16'h0240;
    localparam logic [15:0] TRIG_C_RST   = 16'h0300;
    localparam logic [15:0] TRIG_C_INC   = 16'h0340;
    localparam logic [15:0] TRIG_B_RST   = 16'h0360;
    localparam logic [15:0] TRIG_NMI_ON  = 16'h0380;
    localparam logic [15:0] TRIG_RAM_NXT = 16'h03a0;
    localparam logic [15:0] TRIG_NMI_OFF = 16'h03c0;
    localparam logic [15:0] TRIG_ROM_NXT = 16'h03e0;

    function automatic logic [1:0] bank_advance(input logic [1:0] bank,
                                                input logic [2:0] count);
        logic [2:0] nxt;
        begin
            nxt = {1'b0, bank} + 3'd1;
            if (count == 3'd0 || nxt >= count - 3'd1)
            begin
                bank_advance = 2'd0;
            end
            else
            begin
                bank_advance = nxt[1:0];
            end
        end
    endfunction

    logic [15:0]          a;
    logic [5:0]           a6;
    logic                 low_hit;
    logic                 banked_hit;
    logic [RAM_IDX_W-1:0] ram_idx;
    logic                 ram_ok;

    assign a  = item.address;
    assign a6 = a[5:0];

    assign low_hit    = (a <= 16'h00ff) ||
                        (a >= {2'b00, cfg.ram_low_limit} && a <= 16'h3fff);
    assign banked_hit = (a >= 16'h4000) && (a <= {1'b0, cfg.ram_high_limit});
    assign ram_idx    = (!low_hit && banked_hit)
                      ? {1'b0, a} + {1'b0, ram_bank, 14'd0}
                      : {1'b0, a};
    assign ram_ok     = {1'b0, ram_idx} < RAM_LIMIT;

    always_comb
    begin
        dec               = '0;
        dec.rd_sel        = RD_CONST;
        dec.target        = TGT_NONE;
        dec.action        = ACT_NONE;
        dec.ram_addr      = ram_idx[RAM_AW-1:0];
        dec.rom_addr      = a[ROM_AW-1:0];
        dec.ram_bank_next = ram_bank;
        dec.rom_bank_next = rom_bank;

        if (item.func == FUNC_POWER_OFF)
        begin
            dec.ram_bank_next = 2'd0;
            dec.rom_bank_next = 2'd0;
        end
        else if (item.func == FUNC_ROM_LOAD)
        begin
            dec.rom_we = 1'b1;
        end
        else if (a <= 16'h003f)
        begin
            if (item.func == FUNC_READ)
            begin
                if (a6 inside {REG_TIMER_CTRL, REG_COUNTER_LO, REG_CMP_HI, REG_CMP_LO,
                               REG_TIMER_CTRL2, REG_SCRATCH_A, REG_SCRATCH_B})
                begin
                    dec.rd_sel = RD_RAM;
                end
                else if (a6 == REG_COUNTER_HI)
                begin
                    dec.target = TGT_TIMER;
                    dec.treg   = a6;
                end
                else if (a6 == REG_PORT5)
                begin
                    dec.target = TGT_PORT5;
                    dec.treg   = a6;
                end
                else if (a6 inside {REG_FIXED_20A, REG_FIXED_20B})
                begin
                    dec.rd_const = 8'h20;
                end
                else if (a6 inside {REG_FIXED_FFA, REG_FIXED_FFB})
                begin
                    dec.rd_const = 8'hff;
                end
            end
            else
            begin
                if (a6 inside {REG_TIMER_CTRL, REG_COUNTER_HI, REG_COUNTER_LO,
                               REG_TIMER_CTRL2})
                begin
                    dec.target = TGT_TIMER;
                    dec.treg   = a6;
                end
                else if (a6 inside {REG_CMP_HI, REG_CMP_LO})
                begin
                    dec.ram_we = 1'b1;
                    dec.cmp    = 1'b1;
                end
                else if (a6 inside {REG_SCRATCH_A, REG_SCRATCH_B})
                begin
                    dec.ram_we = 1'b1;
                end
            end
        end
        else if (a >= LCD_BASE && a <= LCD_END)
        begin
            // Upper half of the window is a gap: no target, no store access
            if ((a & BLOCK_MASK) == LCD_BASE)
            begin
                dec.target = TGT_LCD;
                dec.treg   = {5'd0, a[0]};
            end
        end
        else if (a >= TRIG_FIRST && a <= TRIG_LAST)
        begin
            case (a & BLOCK_MASK)
                TRIG_OFF:     dec.action = ACT_SWITCH_OFF;
                TRIG_P_ON:    dec.action = ACT_PULSE_ON;
                TRIG_P_OFF:   dec.action = ACT_PULSE_OFF;
                TRIG_C_RST:   dec.action = ACT_COUNTER_RESET;
                TRIG_C_INC:   dec.action = ACT_COUNTER_INC;
                TRIG_B_RST:
                begin
                    dec.action        = ACT_BANK_RESET;
                    dec.ram_bank_next = 2'd0;
                    dec.rom_bank_next = 2'd0;
                end
                TRIG_NMI_ON:  dec.action = ACT_NMI_ON;
                TRIG_RAM_NXT:
                begin
                    dec.action        = ACT_NEXT_RAM_BANK;
                    dec.ram_bank_next = bank_advance(ram_bank, cfg.ram_bank_count);
                end
                TRIG_NMI_OFF: dec.action = ACT_NMI_OFF;
                TRIG_ROM_NXT:
                begin
                    dec.action        = ACT_NEXT_ROM_BANK;
                    dec.rom_bank_next = bank_advance(rom_bank, cfg.rom_bank_count);
                end
                default:      dec.action = ACT_NONE;
            endcase
            if (dec.action != ACT_NONE)
            begin
                dec.target = TGT_TRIGGER;
            end
        end
        else if (item.func == FUNC_READ)
        begin
            if (low_hit || banked_hit)
            begin
                if (ram_ok)
                begin
                    dec.rd_sel = RD_RAM;
                end
            end
            else if (a[15:14] == 2'b10)
            begin
                case (rom_bank)
                    2'd0:
                    begin
                        dec.rd_sel   = RD_ROM;
                        dec.rom_addr = {2'b00, a[13:0]};
                    end
                    2'd1:
                    begin
                        dec.rd_sel   = RD_ROM;
                        dec.rom_addr = a;
                    end
                    2'd2:
                    begin
                        dec.rd_sel   = RD_ROM;
                        dec.rom_addr = {2'b11, a[13:0]};
                    end
                    default:
                    begin
                        dec.rd_sel = RD_CONST;
                    end
                endcase
            end
            else if (a[15:14] == 2'b11)
            begin
                dec.rd_sel   = RD_ROM;
                dec.rom_addr = {2'b01, a[13:0]};
            end
        end
        else
        begin
            dec.ram_we = (low_hit || banked_hit) && ram_ok;
        end
    end

endmodule

// ----- src/bmmd_store.sv -----
// ----------------------------------------------------------------------------
// Banked memory map decoder: RAM and ROM stores
// Byte stores with registered read data and a RAM clearing pass after reset.
// ----------------------------------------------------------------------------
module bmmd_store
    import bmmd_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  mem_req_t req,
    output logic [7:0] ram_rdata,
    output logic [7:0] rom_rdata,
    output logic     busy
);

    localparam logic [RAM_AW-1:0] CLR_LAST = RAM_AW'(RAM_BYTES - 1);

    logic [7:0] ram_mem [RAM_BYTES];
    logic [7:0] rom_mem [ROM_BYTES];

    logic              clearing_reg;
    logic              clearing_next;
    logic [RAM_AW-1:0] clr_idx_reg;
    logic [RAM_AW-1:0] clr_idx_next;

    logic              ram_we;
    logic [RAM_AW-1:0] ram_waddr;
    logic [7:0]        ram_wdata;

    always_comb
    begin
        clearing_next = clearing_reg;
        clr_idx_next  = clr_idx_reg;
        if (clearing_reg)
        begin
            clr_idx_next = clr_idx_reg + RAM_AW'(1);
            if (clr_idx_reg == CLR_LAST)
            begin
                clearing_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clearing_reg <= 1'b1;
            clr_idx_reg  <= '0;
        end
        else
        begin
            clearing_reg <= clearing_next;
            clr_idx_reg  <= clr_idx_next;
        end
    end

    // The sweep owns the write port; no item is in flight while it runs
    assign ram_we    = clearing_reg || req.ram_we;
    assign ram_waddr = clearing_reg ? clr_idx_reg : req.ram_addr;
    assign ram_wdata = clearing_reg ? 8'd0 : req.wdata;
    assign busy      = clearing_reg;

    always_ff @(posedge clk)
    begin
        if (ram_we)
        begin
            ram_mem[ram_waddr] <= ram_wdata;
        end
        if (req.ram_re)
        begin
            ram_rdata <= ram_mem[req.ram_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.rom_we)
        begin
            rom_mem[req.rom_addr] <= req.wdata;
        end
        if (req.rom_re)
        begin
            rom_rdata <= rom_mem[req.rom_addr];
        end
    end

endmodule
